### rtl/core/modinv_pkg.sv
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared widths, payload structs, status codes and state types for the
// modular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package modinv_pkg;

  localparam int WIDTH = 32;
  localparam int KW    = $clog2(WIDTH);

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NOT_COPRIME,
    STATUS_MOD_ZERO
  } status_t;

  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [WIDTH-1:0] divisor;
    logic [WIDTH-1:0] inverse;
    status_t          status;
  } rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ALIGN,
    DIV_SUB
  } div_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/modular_inverse.sv
// ----------------------------------------------------------------------------
// modular_inverse
// Extended Euclid modular inverse with gcd and status.
// ----------------------------------------------------------------------------
// Each request transaction carries a modulus and a value; the block returns
// one response with their gcd, the inverse of the value in 0..modulus-1 when
// the gcd is one, and a status (ok, not coprime, modulus zero). All work goes
// through one shift-subtract divider: first the reduction of the value by the
// modulus, then one division per Euclid step. A zero modulus skips the
// divider and goes straight to the response. The block takes no new request
// until the current one has been handed to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse
  import modinv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  state_t           state;
  state_t           state_next;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] c0;
  logic [WIDTH-1:0] c1;
  logic             neg0;
  logic             neg1;
  logic             mzero;

  logic             accept;
  logic             load_rsp;
  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_rem;
  logic [WIDTH-1:0] div_acc;
  rsp_t             result;

  modinv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .base     (c0),
    .step     (c1),
    .done     (div_done),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  assign accept = req_valid && req_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (req.modulus == '0) ? ST_DONE : ST_REDUCE;
      end
      ST_REDUCE: if (div_done) state_next = ST_CHECK;
      ST_CHECK:  state_next = (b == '0) ? ST_DONE : ST_STEP;
      ST_STEP:   if (div_done) state_next = ST_CHECK;
      ST_DONE:   if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    load_rsp     = (state == ST_DONE) && (!rsp_valid || rsp_ready);
    div_start    = 1'b0;
    div_dividend = a;
    div_divisor  = b;
    unique case (state)
      ST_IDLE: begin
        // The first pass reduces the value modulo the modulus.
        div_start    = accept && (req.modulus != '0);
        div_dividend = req.value;
        div_divisor  = req.modulus;
      end
      ST_CHECK: div_start = (b != '0);
      default: ;
    endcase
  end

  always_comb begin
    result.divisor = a;
    result.inverse = '0;
    if (mzero) begin
      result.status = STATUS_MOD_ZERO;
    end else if (a != WIDTH'(1)) begin
      result.status = STATUS_NOT_COPRIME;
    end else begin
      result.status = STATUS_OK;
      if (m == WIDTH'(1)) begin
        result.inverse = '0;
      end else if (neg0 && (c0 != '0)) begin
        result.inverse = m - c0;
      end else begin
        result.inverse = c0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= result;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          m     <= req.modulus;
          a     <= req.value;
          mzero <= (req.modulus == '0);
        end
      end
      ST_REDUCE: begin
        if (div_done) begin
          a    <= m;
          b    <= div_rem;
          c0   <= '0;
          neg0 <= 1'b0;
          c1   <= WIDTH'(1);
          neg1 <= 1'b0;
        end
      end
      ST_STEP: begin
        // Shift the remainder pair and the coefficient pair by one step.
        if (div_done) begin
          a    <= b;
          b    <= div_rem;
          c0   <= c1;
          neg0 <= neg1;
          c1   <= div_acc;
          neg1 <= !neg1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/modinv_div.sv
// ----------------------------------------------------------------------------
// modinv_div
// Shift-subtract divider with a coefficient accumulator. Produces the
// remainder of dividend / divisor and base + quotient * step, one quotient
// bit per cycle after aligning the divisor under the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module modinv_div
  import modinv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  input  wire logic [WIDTH-1:0] base,
  input  wire logic [WIDTH-1:0] step,
  output logic                  done,
  output logic [WIDTH-1:0]      rem,
  output logic [WIDTH-1:0]      acc
);

  div_state_t       state;
  div_state_t       state_next;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] cs;
  logic [KW-1:0]    k;
  logic [WIDTH-1:0] dvs_shl;
  logic             can_shift;
  logic             can_sub;
  logic             last_bit;

  assign dvs_shl  = {dvs[WIDTH-2:0], 1'b0};
  // Stop aligning once another doubling would pass the dividend or overflow.
  assign can_shift = !dvs[WIDTH-1] && (dvs_shl <= rem);
  assign can_sub   = (rem >= dvs);

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE:  if (start) state_next = DIV_ALIGN;
      DIV_ALIGN: if (!can_shift) state_next = DIV_SUB;
      DIV_SUB:   if (k == '0) state_next = DIV_IDLE;
      default:   state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    last_bit = (state == DIV_SUB) && (k == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= last_bit;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        if (start) begin
          rem <= dividend;
          dvs <= divisor;
          acc <= base;
          cs  <= step;
          k   <= '0;
        end
      end
      DIV_ALIGN: begin
        if (can_shift) begin
          dvs <= dvs_shl;
          cs  <= {cs[WIDTH-2:0], 1'b0};
          k   <= k + 1'b1;
        end
      end
      DIV_SUB: begin
        if (can_sub) begin
          rem <= rem - dvs;
          acc <= acc + cs;
        end
        if (k != '0) begin
          dvs <= {1'b0, dvs[WIDTH-1:1]};
          cs  <= {1'b0, cs[WIDTH-1:1]};
          k   <= k - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
